// ===== sv/obsd_pkg.sv =====
// ----------------------------------------------------------------------------
// obsd_pkg
// Shared constants and types for the oriented box clearance pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
package obsd_pkg;

  localparam int CORDIC_STEPS = 30;
  localparam int GUARD_BITS   = 8;
  localparam int SQRT_STEPS   = 32;
  localparam int GAIN_Q20     = 636751;
  localparam int OUT_W        = 22;
  localparam int RADIUS_W     = 16;
  localparam int EXTENT_W     = 16;
  localparam int CFG_DATA_W   = 32;
  localparam int CFG_IDX_W    = 3;

  localparam logic signed [OUT_W-1:0] OUT_MAX      = 22'sh1FFFFF;
  localparam logic signed [OUT_W-1:0] OUT_MIN      = -22'sh200000;
  localparam logic signed [OUT_W-1:0] INSIDE_VALUE = -22'sd16;
  localparam logic signed [63:0]      EXCESS_CLAMP = 64'sd1073741824;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X        = 3'd0,
    REG_CENTER_Y        = 3'd1,
    REG_HEADING         = 3'd2,
    REG_BOX_LENGTH      = 3'd3,
    REG_BOX_WIDTH       = 3'd4,
    REG_OBSTACLE_ENABLE = 3'd5,
    REG_DISTANCE_ACTIVE = 3'd6,
    REG_UNUSED          = 3'd7
  } cfg_reg_t;

  localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

endpackage
`default_nettype wire

// ===== sv/obsd_if.sv =====
// ----------------------------------------------------------------------------
// obsd_if
// Request channels: query input, clearance result and register write.
// ----------------------------------------------------------------------------
`default_nettype none
interface obsd_in_if #(parameter int COORD_BITS = 20);
  logic                                  valid;
  logic                                  ready;
  logic signed [COORD_BITS-1:0]          point_x;
  logic signed [COORD_BITS-1:0]          point_y;
  logic [obsd_pkg::RADIUS_W-1:0]         clearance_radius;
  modport source (output valid, point_x, point_y, clearance_radius, input ready);
  modport sink   (input valid, point_x, point_y, clearance_radius, output ready);
endinterface

interface obsd_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [obsd_pkg::OUT_W-1:0]     clearance;
  logic                                  is_inside;
  logic                                  is_disabled;
  modport source (output valid, clearance, is_inside, is_disabled, input ready);
  modport sink   (input valid, clearance, is_inside, is_disabled, output ready);
endinterface

interface obsd_cfg_if;
  logic                                  valid;
  logic                                  ready;
  logic [obsd_pkg::CFG_IDX_W-1:0]        index;
  logic [obsd_pkg::CFG_DATA_W-1:0]       data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== sv/obsd_cordic.sv =====
// ----------------------------------------------------------------------------
// obsd_cordic
// Pipelined CORDIC rotation, one micro-rotation per register stage.
// ----------------------------------------------------------------------------
`default_nettype none
module obsd_cordic #(
  parameter int W  = 31,
  parameter int SW = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                ce,
  input  wire logic                in_valid,
  input  wire logic signed [W-1:0] in_x,
  input  wire logic signed [W-1:0] in_y,
  input  wire logic signed [31:0]  in_z,
  input  wire logic [SW-1:0]       in_side,
  output logic                     out_valid,
  output logic signed [W-1:0]      out_x,
  output logic signed [W-1:0]      out_y,
  output logic [SW-1:0]            out_side
);
  localparam int N = obsd_pkg::CORDIC_STEPS;

  logic                vld_r  [1:N];
  logic signed [W-1:0] x_r    [1:N];
  logic signed [W-1:0] y_r    [1:N];
  logic signed [31:0]  z_r    [1:N];
  logic [SW-1:0]       side_r [1:N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic                vi;
    logic signed [W-1:0] xi;
    logic signed [W-1:0] yi;
    logic signed [31:0]  zi;
    logic [SW-1:0]       si;
    if (i == 0) begin : g_first
      assign vi = in_valid;
      assign xi = in_x;
      assign yi = in_y;
      assign zi = in_z;
      assign si = in_side;
    end else begin : g_next
      assign vi = vld_r[i];
      assign xi = x_r[i];
      assign yi = y_r[i];
      assign zi = z_r[i];
      assign si = side_r[i];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else if (ce) begin
        vld_r[i+1] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        side_r[i+1] <= si;
        if (!zi[31]) begin
          x_r[i+1] <= xi + (yi >>> i);
          y_r[i+1] <= yi - (xi >>> i);
          z_r[i+1] <= zi - $signed(obsd_pkg::ATAN_TAB[i]);
        end else begin
          x_r[i+1] <= xi - (yi >>> i);
          y_r[i+1] <= yi + (xi >>> i);
          z_r[i+1] <= zi + $signed(obsd_pkg::ATAN_TAB[i]);
        end
      end
    end
  end

  assign out_valid = vld_r[N];
  assign out_x     = x_r[N];
  assign out_y     = y_r[N];
  assign out_side  = side_r[N];
endmodule
`default_nettype wire

// ===== sv/obsd_isqrt.sv =====
// ----------------------------------------------------------------------------
// obsd_isqrt
// Pipelined 64-bit integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none
module obsd_isqrt #(
  parameter int SW = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          ce,
  input  wire logic          in_valid,
  input  wire logic [63:0]   in_n,
  input  wire logic [SW-1:0] in_side,
  output logic               out_valid,
  output logic [31:0]        out_root,
  output logic [SW-1:0]      out_side
);
  localparam int N = obsd_pkg::SQRT_STEPS;

  logic          vld_r  [1:N];
  logic [63:0]   n_r    [1:N];
  logic [63:0]   res_r  [1:N];
  logic [SW-1:0] side_r [1:N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    logic          vi;
    logic [63:0]   ni;
    logic [63:0]   ri;
    logic [SW-1:0] si;
    logic [63:0]   trial;
    if (k == 0) begin : g_first
      assign vi = in_valid;
      assign ni = in_n;
      assign ri = '0;
      assign si = in_side;
    end else begin : g_next
      assign vi = vld_r[k];
      assign ni = n_r[k];
      assign ri = res_r[k];
      assign si = side_r[k];
    end
    assign trial = ri + BIT;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (ce) begin
        vld_r[k+1] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        side_r[k+1] <= si;
        if (ni >= trial) begin
          n_r[k+1]   <= ni - trial;
          res_r[k+1] <= (ri >> 1) + BIT;
        end else begin
          n_r[k+1]   <= ni;
          res_r[k+1] <= ri >> 1;
        end
      end
    end
  end

  assign out_valid = vld_r[N];
  assign out_root  = res_r[N][31:0];
  assign out_side  = side_r[N];
endmodule
`default_nettype wire

// ===== sv/oriented_box_signed_distance.sv =====
// ----------------------------------------------------------------------------
// oriented_box_signed_distance
// Clearance from a query point to a configured oriented rectangle.
// ----------------------------------------------------------------------------
//  channel  | dir | contents
//  in_ch    | in  | point_x, point_y, clearance_radius
//  out_ch   | out | clearance, is_inside, is_disabled
//  cfg_ch   | in  | index, data (register write)
//
//  One request per cycle while out_ch is not stalled; the pipeline has one offset stage,
//  30 CORDIC stages, four scaling/excess/square/sum stages, 32 square root
//  stages and the output register.
//  Reset is synchronous, active low; it clears valid bits and sets the configuration registers.
//  A stall on out_ch freezes the whole pipeline; nothing is dropped.
// ----------------------------------------------------------------------------
`default_nettype none
module oriented_box_signed_distance #(
  parameter int COORD_BITS = 20,
  parameter int ANGLE_BITS = 16
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  obsd_in_if.sink     in_ch,
  obsd_out_if.source  out_ch,
  obsd_cfg_if.sink    cfg_ch
);
  localparam int W   = COORD_BITS + 11;
  localparam int PW  = W + 21;
  localparam int UW  = PW - 27;
  localparam int EW  = UW + 2;
  localparam int RW  = obsd_pkg::RADIUS_W;
  localparam int XW  = obsd_pkg::EXTENT_W;
  localparam int SSW = RW + 2 + EW;

  // configuration registers
  logic signed [COORD_BITS-1:0] center_x_r;
  logic signed [COORD_BITS-1:0] center_y_r;
  logic [ANGLE_BITS-1:0]        heading_r;
  logic [XW-1:0]                box_length_r;
  logic [XW-1:0]                box_width_r;
  logic                         obstacle_enable_r;
  logic                         distance_active_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r        <= '0;
      center_y_r        <= '0;
      heading_r         <= '0;
      box_length_r      <= '0;
      box_width_r       <= '0;
      obstacle_enable_r <= 1'b1;
      distance_active_r <= 1'b1;
    end else if (cfg_ch.valid) begin
      unique case (obsd_pkg::cfg_reg_t'(cfg_ch.index))
        obsd_pkg::REG_CENTER_X:        center_x_r <= cfg_ch.data[COORD_BITS-1:0];
        obsd_pkg::REG_CENTER_Y:        center_y_r <= cfg_ch.data[COORD_BITS-1:0];
        obsd_pkg::REG_HEADING:         heading_r <= cfg_ch.data[ANGLE_BITS-1:0];
        obsd_pkg::REG_BOX_LENGTH:      box_length_r <= cfg_ch.data[XW-1:0];
        obsd_pkg::REG_BOX_WIDTH:       box_width_r <= cfg_ch.data[XW-1:0];
        obsd_pkg::REG_OBSTACLE_ENABLE: obstacle_enable_r <= cfg_ch.data[0];
        obsd_pkg::REG_DISTANCE_ACTIVE: distance_active_r <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  // global advance
  logic out_valid_r;
  logic ce;
  assign ce          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = ce;

  // stage 0: offset, quadrant fold, start angle
  logic [31:0]         ang;
  logic [32:0]         ang_sum;
  logic [1:0]          quad;
  logic signed [31:0]  z0;
  logic signed [W-1:0] dx;
  logic signed [W-1:0] dy;
  logic signed [W-1:0] x0;
  logic signed [W-1:0] y0;

  always_comb begin
    ang     = 32'(heading_r) << (32 - ANGLE_BITS);
    ang_sum = {1'b0, ang} + 33'h020000000;
    quad    = ang_sum[31:30];
    z0      = $signed(ang - {quad, 30'd0});
    dx      = (W'(in_ch.point_x) - W'(center_x_r)) <<< obsd_pkg::GUARD_BITS;
    dy      = (W'(in_ch.point_y) - W'(center_y_r)) <<< obsd_pkg::GUARD_BITS;
    case (quad)
      2'd1:    begin x0 = dy;  y0 = -dx; end
      2'd2:    begin x0 = -dx; y0 = -dy; end
      2'd3:    begin x0 = -dy; y0 = dx;  end
      default: begin x0 = dx;  y0 = dy;  end
    endcase
  end

  logic                s0_vld_r;
  logic signed [W-1:0] s0_x_r;
  logic signed [W-1:0] s0_y_r;
  logic signed [31:0]  s0_z_r;
  logic [RW-1:0]       s0_rad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (ce) begin
      s0_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s0_x_r   <= x0;
      s0_y_r   <= y0;
      s0_z_r   <= z0;
      s0_rad_r <= in_ch.clearance_radius;
    end
  end

  logic                c_vld;
  logic signed [W-1:0] c_x;
  logic signed [W-1:0] c_y;
  logic [RW-1:0]       c_rad;

  obsd_cordic #(.W(W), .SW(RW)) u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .ce        (ce),
    .in_valid  (s0_vld_r),
    .in_x      (s0_x_r),
    .in_y      (s0_y_r),
    .in_z      (s0_z_r),
    .in_side   (s0_rad_r),
    .out_valid (c_vld),
    .out_x     (c_x),
    .out_y     (c_y),
    .out_side  (c_rad)
  );

  // stage A: gain correction
  logic                 sa_vld_r;
  logic signed [PW-1:0] sa_px_r;
  logic signed [PW-1:0] sa_py_r;
  logic [RW-1:0]        sa_rad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sa_vld_r <= 1'b0;
    end else if (ce) begin
      sa_vld_r <= c_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      sa_px_r  <= PW'(c_x) * PW'(obsd_pkg::GAIN_Q20);
      sa_py_r  <= PW'(c_y) * PW'(obsd_pkg::GAIN_Q20);
      sa_rad_r <= c_rad;
    end
  end

  // stage B: round to half units, axis excesses
  logic signed [PW-1:0] px_rnd;
  logic signed [PW-1:0] py_rnd;
  logic signed [UW-1:0] u_v;
  logic signed [UW-1:0] v_v;
  logic signed [EW-1:0] ex_nxt;
  logic signed [EW-1:0] ey_nxt;

  always_comb begin
    px_rnd = (sa_px_r + (PW'(1) <<< 26)) >>> 27;
    py_rnd = (sa_py_r + (PW'(1) <<< 26)) >>> 27;
    u_v    = px_rnd[UW-1:0];
    v_v    = py_rnd[UW-1:0];
    ex_nxt = (u_v[UW-1] ? -EW'(u_v) : EW'(u_v)) - $signed(EW'(box_length_r));
    ey_nxt = (v_v[UW-1] ? -EW'(v_v) : EW'(v_v)) - $signed(EW'(box_width_r));
  end

  logic                 sb_vld_r;
  logic signed [EW-1:0] sb_ex_r;
  logic signed [EW-1:0] sb_ey_r;
  logic [RW-1:0]        sb_rad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sb_vld_r <= 1'b0;
    end else if (ce) begin
      sb_vld_r <= sa_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      sb_ex_r  <= ex_nxt;
      sb_ey_r  <= ey_nxt;
      sb_rad_r <= sa_rad_r;
    end
  end

  // stage C: classify, clamp and square
  logic signed [63:0] ex64;
  logic signed [63:0] ey64;
  logic [30:0]        exc;
  logic [30:0]        eyc;

  always_comb begin
    ex64 = 64'(sb_ex_r);
    ey64 = 64'(sb_ey_r);
    exc  = (ex64 > obsd_pkg::EXCESS_CLAMP) ? 31'h40000000 : ex64[30:0];
    eyc  = (ey64 > obsd_pkg::EXCESS_CLAMP) ? 31'h40000000 : ey64[30:0];
  end

  logic                 sc_vld_r;
  logic [61:0]          sc_sqx_r;
  logic [61:0]          sc_sqy_r;
  logic                 sc_inside_r;
  logic                 sc_corner_r;
  logic signed [EW-1:0] sc_dlin_r;
  logic [RW-1:0]        sc_rad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_vld_r <= 1'b0;
    end else if (ce) begin
      sc_vld_r <= sb_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      sc_sqx_r    <= 62'(exc) * 62'(exc);
      sc_sqy_r    <= 62'(eyc) * 62'(eyc);
      sc_inside_r <= sb_ex_r[EW-1] && sb_ey_r[EW-1];
      sc_corner_r <= !sb_ex_r[EW-1] && !sb_ey_r[EW-1];
      sc_dlin_r   <= sb_ex_r[EW-1] ? sb_ey_r : sb_ex_r;
      sc_rad_r    <= sb_rad_r;
    end
  end

  // stage D: sum of squares
  logic          sd_vld_r;
  logic [63:0]   sd_sum_r;
  logic [SSW-1:0] sd_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sd_vld_r <= 1'b0;
    end else if (ce) begin
      sd_vld_r <= sc_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      sd_sum_r  <= 64'(sc_sqx_r) + 64'(sc_sqy_r);
      sd_side_r <= {sc_rad_r, sc_inside_r, sc_corner_r, sc_dlin_r};
    end
  end

  logic           q_vld;
  logic [31:0]    q_root;
  logic [SSW-1:0] q_side;

  obsd_isqrt #(.SW(SSW)) u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .ce        (ce),
    .in_valid  (sd_vld_r),
    .in_n      (sd_sum_r),
    .in_side   (sd_side_r),
    .out_valid (q_vld),
    .out_root  (q_root),
    .out_side  (q_side)
  );

  // final: subtract radius, halve, saturate, then apply disabled and inside overrides
  logic [RW-1:0]            f_rad;
  logic                     f_inside;
  logic                     f_corner;
  logic signed [EW-1:0]     f_dlin;
  logic signed [65:0]       f_d;
  logic signed [65:0]       f_c;
  logic signed [obsd_pkg::OUT_W-1:0] clr_nxt;
  logic                     ins_nxt;
  logic                     dis_nxt;

  always_comb begin
    {f_rad, f_inside, f_corner, f_dlin} = q_side;
    f_d = f_corner ? 66'($signed({1'b0, q_root})) : 66'(f_dlin);
    f_c = (f_d - $signed(66'(f_rad) << 1) + 66'sd1) >>> 1;
    if (f_c > 66'(obsd_pkg::OUT_MAX)) begin
      clr_nxt = obsd_pkg::OUT_MAX;
    end else if (f_c < 66'(obsd_pkg::OUT_MIN)) begin
      clr_nxt = obsd_pkg::OUT_MIN;
    end else begin
      clr_nxt = f_c[obsd_pkg::OUT_W-1:0];
    end
    ins_nxt = 1'b0;
    dis_nxt = 1'b0;
    if (!obstacle_enable_r || !distance_active_r) begin
      clr_nxt = obsd_pkg::OUT_MAX;
      dis_nxt = 1'b1;
    end else if (f_inside) begin
      clr_nxt = obsd_pkg::INSIDE_VALUE;
      ins_nxt = 1'b1;
    end
  end

  logic signed [obsd_pkg::OUT_W-1:0] clr_r;
  logic                              ins_r;
  logic                              dis_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ce) begin
      out_valid_r <= q_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      clr_r <= clr_nxt;
      ins_r <= ins_nxt;
      dis_r <= dis_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.clearance   = clr_r;
  assign out_ch.is_inside   = ins_r;
  assign out_ch.is_disabled = dis_r;

`ifndef SYNTHESIS
  a_inside_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && ins_r |-> clr_r == obsd_pkg::INSIDE_VALUE && !dis_r)
    else $error("inside result carries wrong clearance");
  a_disabled_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && dis_r |-> clr_r == obsd_pkg::OUT_MAX)
    else $error("disabled result not at maximum");
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> out_valid_r && $stable(clr_r))
    else $error("stalled result changed");
  a_ready_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |-> !in_ch.ready)
    else $error("request taken while pipeline frozen");
`endif
endmodule
`default_nettype wire

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Checks the oriented box clearance pipeline against a bit-accurate predictor.
// Queries go through directed corners, register sweeps and random batches
// under random idling and back-pressure (off in the tail test); each result is checked in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb;

  localparam int CB = 20;
  localparam int AB = 16;
  localparam int LATENCY = 68;
  localparam int WD_LIMIT = 4000;

  typedef struct packed {
    logic signed [obsd_pkg::OUT_W-1:0] clearance;
    logic                              is_inside;
    logic                              is_disabled;
  } clr_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  obsd_in_if #(.COORD_BITS(CB)) in_ch();
  obsd_out_if out_ch();
  obsd_cfg_if cfg_ch();

  oriented_box_signed_distance #(.COORD_BITS(CB), .ANGLE_BITS(AB)) u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  logic signed [CB-1:0] box_cx, box_cy;
  logic [AB-1:0]        box_hd;
  logic [15:0]          box_len, box_wid;
  logic                 box_en, box_act;

  clr_t clr_expected[$];
  int   n_err = 0;
  int   n_sent = 0;
  int   n_seen = 0;
  int   n_inside = 0;
  int   n_corner = 0;
  int   idle_cycles = 0;
  bit   tail_mode = 1'b0;
  int   hold_off = 0;
  logic [31:0] atan_lut [obsd_pkg::CORDIC_STEPS];

  function automatic longint asr64(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint isqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic clr_t predict_clearance(logic signed [CB-1:0] px,
                                             logic signed [CB-1:0] py,
                                             logic [15:0] rad);
    clr_t r;
    longint x, y, z, t, xs, ys, u, v, ex, ey, d, c;
    logic [31:0] a, rr;
    logic [1:0] q;
    r.clearance = obsd_pkg::OUT_MAX;
    r.is_inside = 1'b0;
    r.is_disabled = 1'b1;
    if (!box_en || !box_act) return r;
    r.is_disabled = 1'b0;
    x = (longint'(px) - longint'(box_cx)) * 256;
    y = (longint'(py) - longint'(box_cy)) * 256;
    a = {box_hd, 16'd0};
    q = 2'((({32'd0, a} + 64'd536870912) >> 30) & 3);
    rr = a - {q, 30'd0};
    z = longint'(signed'(rr));
    if (q == 2'd1) begin
      t = x; x = y; y = -t;
    end else if (q == 2'd2) begin
      x = -x; y = -y;
    end else if (q == 2'd3) begin
      t = x; x = -y; y = t;
    end
    for (int i = 0; i < obsd_pkg::CORDIC_STEPS; i++) begin
      xs = asr64(x, i);
      ys = asr64(y, i);
      if (z >= 0) begin
        x = x + ys; y = y - xs; z -= longint'(atan_lut[i]);
      end else begin
        x = x - ys; y = y + xs; z += longint'(atan_lut[i]);
      end
    end
    u = asr64(x * obsd_pkg::GAIN_Q20 + (64'sd1 <<< 26), 27);
    v = asr64(y * obsd_pkg::GAIN_Q20 + (64'sd1 <<< 26), 27);
    ex = (u < 0 ? -u : u) - longint'(box_len);
    ey = (v < 0 ? -v : v) - longint'(box_wid);
    if (ex < 0 && ey < 0) begin
      r.clearance = obsd_pkg::INSIDE_VALUE;
      r.is_inside = 1'b1;
      return r;
    end
    if (ex < 0) d = ey;
    else if (ey < 0) d = ex;
    else begin
      if (ex > obsd_pkg::EXCESS_CLAMP) ex = obsd_pkg::EXCESS_CLAMP;
      if (ey > obsd_pkg::EXCESS_CLAMP) ey = obsd_pkg::EXCESS_CLAMP;
      d = isqrt(longint'(ex * ex + ey * ey));
    end
    c = asr64(d - 2 * longint'(rad) + 1, 1);
    if (c > longint'(obsd_pkg::OUT_MAX)) c = obsd_pkg::OUT_MAX;
    if (c < longint'(obsd_pkg::OUT_MIN)) c = obsd_pkg::OUT_MIN;
    r.clearance = c[obsd_pkg::OUT_W-1:0];
    return r;
  endfunction

  task automatic random_idle();
    int n;
    if (!tail_mode && $urandom_range(0, 7) == 0) begin
      n = $urandom_range(1, 16);
      in_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_query(logic signed [CB-1:0] px, logic signed [CB-1:0] py,
                            logic [15:0] rad);
    clr_t e;
    random_idle();
    in_ch.valid <= 1'b1;
    in_ch.point_x <= px;
    in_ch.point_y <= py;
    in_ch.clearance_radius <= rad;
    do @(posedge clk); while (!in_ch.ready);
    e = predict_clearance(px, py, rad);
    if (e.is_inside) n_inside++;
    clr_expected.push_back(e);
    n_sent++;
  endtask

  task automatic write_reg(obsd_pkg::cfg_reg_t idx, logic [31:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      obsd_pkg::REG_CENTER_X:        box_cx = data[CB-1:0];
      obsd_pkg::REG_CENTER_Y:        box_cy = data[CB-1:0];
      obsd_pkg::REG_HEADING:         box_hd = data[AB-1:0];
      obsd_pkg::REG_BOX_LENGTH:      box_len = data[15:0];
      obsd_pkg::REG_BOX_WIDTH:       box_wid = data[15:0];
      obsd_pkg::REG_OBSTACLE_ENABLE: box_en = data[0];
      obsd_pkg::REG_DISTANCE_ACTIVE: box_act = data[0];
      default: ;
    endcase
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (clr_expected.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_box(logic [31:0] cx, logic [31:0] cy, logic [31:0] hd,
                         logic [31:0] ln, logic [31:0] wd, logic en, logic act);
    drain();
    write_reg(obsd_pkg::REG_CENTER_X, cx);
    write_reg(obsd_pkg::REG_CENTER_Y, cy);
    write_reg(obsd_pkg::REG_HEADING, hd);
    write_reg(obsd_pkg::REG_BOX_LENGTH, ln);
    write_reg(obsd_pkg::REG_BOX_WIDTH, wd);
    write_reg(obsd_pkg::REG_OBSTACLE_ENABLE, {31'd0, en});
    write_reg(obsd_pkg::REG_DISTANCE_ACTIVE, {31'd0, act});
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic signed [CB-1:0] rand_coord(logic signed [CB-1:0] base,
                                                      int span);
    int off;
    if ($urandom_range(0, 9) == 0) return CB'($urandom);
    off = $urandom_range(0, 2 * span) - span;
    return base + CB'(off);
  endfunction

  task automatic test_reset_defaults();
    send_query(20'sd0, 20'sd0, 16'd0);
    send_query(20'sd100, -20'sd50, 16'd3);
    send_query(20'h7FFFF, 20'h80000, 16'hFFFF);
  endtask

  task automatic test_directed_cases();
    set_box(32'd0, 32'd0, 32'd0, 32'd160, 32'd80, 1'b1, 1'b1);
    send_query(20'sd0, 20'sd0, 16'd0);
    send_query(20'sd10, 20'sd5, 16'd7);
    send_query(20'sd80, 20'sd0, 16'd0);
    send_query(20'sd200, 20'sd0, 16'd1);
    send_query(20'sd0, 20'sd300, 16'd40000);
    send_query(20'sd200, 20'sd200, 16'd5);
    send_query(20'h7FFFF, 20'h7FFFF, 16'd0);
    send_query(20'h80000, 20'h80000, 16'hFFFF);
    send_query(20'h80000, 20'h7FFFF, 16'd0);
    set_box(32'h0007FFFF, 32'hFFF80000, 32'h0000FFFF, 32'hFFFF, 32'hFFFF, 1'b1, 1'b1);
    send_query(20'h80000, 20'h7FFFF, 16'd0);
    send_query(20'h7FFFF, 20'h80000, 16'd0);
    send_query(20'sd0, 20'sd0, 16'd2);
    set_box(32'hFFF00010, 32'd16, 32'h12344000, 32'd0, 32'd0, 1'b1, 1'b1);
    send_query(20'sd16, 20'sd16, 16'd0);
    send_query(20'sd17, 20'sd16, 16'd0);
    set_box(32'd0, 32'd0, 32'd0, 32'd100, 32'd100, 1'b0, 1'b1);
    send_query(20'sd1, 20'sd1, 16'd1);
    set_box(32'd0, 32'd0, 32'd0, 32'd100, 32'd100, 1'b1, 1'b0);
    send_query(20'sd1, 20'sd1, 16'd1);
    set_box(32'd0, 32'd0, 32'd16384, 32'd100, 32'd30, 1'b1, 1'b1);
    send_query(20'sd0, 20'sd40, 16'd0);
    send_query(20'sd40, 20'sd0, 16'd0);
  endtask

  task automatic random_batch(int count, bit small_box);
    logic [31:0] cx, cy, ln, wd;
    cx = $urandom;
    cy = $urandom;
    ln = small_box ? $urandom_range(0, 2000) : $urandom;
    wd = small_box ? $urandom_range(0, 2000) : $urandom;
    set_box(cx, cy, $urandom, ln, wd, $urandom_range(0, 9) != 0,
            $urandom_range(0, 9) != 0);
    for (int i = 0; i < count; i++)
      send_query(rand_coord(box_cx, 1500), rand_coord(box_cy, 1500),
                 $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 200)));
  endtask

  task automatic test_random_boxes();
    for (int b = 0; b < 12; b++) random_batch(35, b % 3 != 2);
  endtask

  task automatic test_backpressure_fill();
    set_box(32'd0, 32'd0, 32'd8000, 32'd500, 32'd300, 1'b1, 1'b1);
    hold_off = 300;
    for (int i = 0; i < 90; i++)
      send_query(rand_coord(20'sd0, 900), rand_coord(20'sd0, 900), 16'($urandom_range(0, 50)));
    drain();
  endtask

  task automatic test_tail_streaming();
    tail_mode = 1'b1;
    random_batch(40, 1'b1);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ch.ready <= 1'b0;
    end else if (idle_cycles > 0) begin
      idle_cycles <= idle_cycles - 1;
      out_ch.ready <= 1'b0;
    end else if (!tail_mode && $urandom_range(0, 11) == 0) begin
      idle_cycles <= $urandom_range(0, 15);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    clr_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      n_seen++;
      if (clr_expected.size() == 0) begin
        $error("unexpected result clearance=%0d", out_ch.clearance);
        n_err++;
      end else begin
        e = clr_expected.pop_front();
        if (out_ch.clearance !== e.clearance) begin
          $error("clearance expected %0d actual %0d", e.clearance, out_ch.clearance);
          n_err++;
        end
        if (out_ch.is_inside !== e.is_inside) begin
          $error("is_inside expected %0b actual %0b", e.is_inside, out_ch.is_inside);
          n_err++;
        end
        if (out_ch.is_disabled !== e.is_disabled) begin
          $error("is_disabled expected %0b actual %0b", e.is_disabled, out_ch.is_disabled);
          n_err++;
        end
      end
    end
  end

  int stuck = 0;
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || hold_off > 0)
      stuck <= 0;
    else
      stuck <= stuck + 1;
    if (stuck >= WD_LIMIT) begin
      $display("watchdog: no progress, %0d results outstanding", clr_expected.size());
      $display("oriented_box_signed_distance regression: fail");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < obsd_pkg::CORDIC_STEPS; i++) atan_lut[i] = obsd_pkg::ATAN_TAB[i];
    in_ch.valid = 1'b0;
    in_ch.point_x = '0;
    in_ch.point_y = '0;
    in_ch.clearance_radius = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = obsd_pkg::REG_CENTER_X;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;
    box_cx = '0; box_cy = '0; box_hd = '0; box_len = '0; box_wid = '0;
    box_en = 1'b1; box_act = 1'b1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_directed_cases();
    test_random_boxes();
    test_backpressure_fill();
    test_tail_streaming();
    drain();
    repeat (LATENCY + 10) @(posedge clk);
    $display("covered %0d queries, %0d results, %0d inside hits, over many box settings",
             n_sent, n_seen, n_inside);
    if (n_err == 0 && clr_expected.size() == 0)
      $display("oriented_box_signed_distance regression: pass");
    else
      $display("oriented_box_signed_distance regression: fail");
    $finish;
  end
endmodule
